// ===== rtl/plucked_string_synth_top_assert.svh =====
// ----------------------------------------------------------------------------
// plucked string synth assertion macros
// concurrent checks on clk with arst_n as disable, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef PLUCKED_STRING_SYNTH_TOP_ASSERT_SVH
`define PLUCKED_STRING_SYNTH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds on every edge outside reset
`define PSS_ASSERT(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// trigger implies outcome on the next edge
`define PSS_ASSERT_NEXT(lbl, trig, outcome, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (outcome)) else $error(msg);
`else
`define PSS_ASSERT(lbl, cond, msg)
`define PSS_ASSERT_NEXT(lbl, trig, outcome, msg)
`endif
`endif

// ===== rtl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// types and constants of the stereo plucked string synthesizer
// ----------------------------------------------------------------------------
package pss_pkg;

	localparam int ADDR_W    = 5;
	localparam int DLEN_W    = 10;
	localparam int FIELD_W   = 16;
	localparam int COEF_W    = 16;

	localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd64881;
	localparam logic [9:0]  RST_DELAY_LENGTH  = 10'd240;
	localparam logic [15:0] RST_NOISE_STEP    = 16'd136;
	localparam logic [15:0] RST_COEF_B0       = 16'd1008;
	localparam logic [15:0] RST_COEF_B1       = 16'd1008;
	localparam logic [15:0] RST_COEF_A1       = 16'hC7DF;
	localparam logic [15:0] FULL_LEVEL        = 16'hFFFF;

	typedef enum logic [2:0] {
		REG_FEEDBACK_GAIN,
		REG_DELAY_LENGTH,
		REG_NOISE_STEP,
		REG_COEF_B0,
		REG_COEF_B1,
		REG_COEF_A1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_RD,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_M5,
		ST_M6,
		ST_WR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               pluck;
		logic signed [15:0] noise_left;
		logic signed [15:0] noise_right;
	} in_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
	} out_t;

endpackage

// ===== rtl/plucked_string_synth_top.sv =====
// ----------------------------------------------------------------------------
// plucked_string_synth_top
// stereo karplus-strong string: delay line, per-channel low-pass, loop gain
// and decaying noise burst, computed on one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
//  channel   signals                                   dir   payload
//  sample    sample_valid, sample_ready, sample        in    pss_pkg::in_t
//  result    result_valid, result_ready, result        out   pss_pkg::out_t
//  config    psel, penable, pwrite, paddr, pwdata,     in    six registers
//            prdata, pready                            out   at 4*index
//
//  after the sample transfer the block steps through length wrap and delay
//  read, then per channel seven steps in which one multiplier (17 x
//  SAMPLE_BITS) does five products, then delay write and output load; a
//  delay_length at or above DELAY_DEPTH repeats the length wrap step once
//  per wrap of the length
//  sample_ready is high only when idle; a stalled result holds the block
//  in its output step until the result register frees up
//  no clearing pass: a fill flag marks delay entries not yet written,
//  which read as zero
// ----------------------------------------------------------------------------
module plucked_string_synth_top #(
	parameter int DELAY_DEPTH = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  pss_pkg::in_t                sample,
	output logic                        result_valid,
	input  logic                        result_ready,
	output pss_pkg::out_t               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pss_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import pss_pkg::*;

	localparam int AW     = $clog2(DELAY_DEPTH);
	localparam int CW     = ((AW > DLEN_W) ? AW : DLEN_W) + 1;
	localparam int SB     = SAMPLE_BITS;
	localparam int PW     = 17 + SB;
	localparam int ACC_W  = ((PW > 32) ? PW : 32) + 2;
	localparam int XW     = (SB > 16) ? SB : 16;
	localparam int SH_UP  = (SB >= 16) ? SB - 16 : 0;
	localparam int SH_DN  = (SB < 16) ? 16 - SB : 0;

	localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
	localparam logic [AW-1:0] LAST_POS = AW'(DELAY_DEPTH - 1);
	localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((2 ** (SB - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] S32MAX = {{(ACC_W - 31){1'b0}}, {31{1'b1}}};
	localparam logic signed [ACC_W-1:0] S32MIN = ~S32MAX;
	localparam logic signed [ACC_W-1:0] HALF_C = ACC_W'(8192);

	// configuration registers
	logic [15:0]       feedback_gain_q;
	logic [DLEN_W-1:0] delay_length_q;
	logic [15:0]       noise_step_q;
	logic [15:0]       coef_b0_q;
	logic [15:0]       coef_b1_q;
	logic [15:0]       coef_a1_q;

	state_t state_q, state_d;

	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     rp_q;
	logic              full_q;
	logic              rd_ok_q;
	logic [DLEN_W-1:0] len_q;
	logic [15:0]       nl_q;
	logic              ch_q;
	logic signed [SB-1:0] ns_q [2];
	logic signed [SB-1:0] o_q [2];
	logic signed [31:0]   s_q [2];
	logic [2*SB-1:0]      rd_q;
	logic signed [PW-1:0]    p_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SB-1:0]    y_q;
	logic signed [PW-17:0]   fb_q;
	logic              result_valid_q;
	out_t              result_q;

	logic [2*SB-1:0]   delay_mem [DELAY_DEPTH];

	logic                 in_xfer;
	logic                 cfg_wr;
	logic [CW-1:0]        len_ext;
	logic [CW:0]          diff;
	logic                 len_big;
	logic signed [SB-1:0] x;
	logic signed [16:0]   mul_a;
	logic signed [SB-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] sdiff;
	logic signed [ACC_W-1:0] osum;
	logic signed [XW-1:0] nx_l, nx_r, ox_l, ox_r;
	logic signed [SB-1:0] ns_l, ns_r;
	logic                 out_free;

	function automatic logic signed [SB-1:0] sat_s(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
		return SB'(t);
	endfunction

	function automatic logic signed [31:0] sat_32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = (v > S32MAX) ? S32MAX : ((v < S32MIN) ? S32MIN : v);
		return 32'(t);
	endfunction

	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite && pready;
	assign in_xfer      = sample_valid && sample_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || result_ready;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feedback_gain_q <= RST_FEEDBACK_GAIN;
			delay_length_q  <= RST_DELAY_LENGTH;
			noise_step_q    <= RST_NOISE_STEP;
			coef_b0_q       <= RST_COEF_B0;
			coef_b1_q       <= RST_COEF_B1;
			coef_a1_q       <= RST_COEF_A1;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_FEEDBACK_GAIN: feedback_gain_q <= pwdata[15:0];
				REG_DELAY_LENGTH:  delay_length_q  <= pwdata[DLEN_W-1:0];
				REG_NOISE_STEP:    noise_step_q    <= pwdata[15:0];
				REG_COEF_B0:       coef_b0_q       <= pwdata[15:0];
				REG_COEF_B1:       coef_b1_q       <= pwdata[15:0];
				REG_COEF_A1:       coef_a1_q       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_FEEDBACK_GAIN: prdata = {16'd0, feedback_gain_q};
			REG_DELAY_LENGTH:  prdata = {{(32 - DLEN_W){1'b0}}, delay_length_q};
			REG_NOISE_STEP:    prdata = {16'd0, noise_step_q};
			REG_COEF_B0:       prdata = {16'd0, coef_b0_q};
			REG_COEF_B1:       prdata = {16'd0, coef_b1_q};
			REG_COEF_A1:       prdata = {16'd0, coef_a1_q};
			default:           prdata = 32'd0;
		endcase
	end

	// noise rescaled to the sample format, floor on the way down
	assign nx_l = XW'(sample.noise_left);
	assign nx_r = XW'(sample.noise_right);
	assign ns_l = SB'((nx_l <<< SH_UP) >>> SH_DN);
	assign ns_r = SB'((nx_r <<< SH_UP) >>> SH_DN);

	// sample back to the 16 bit field
	assign ox_l = XW'(o_q[0]);
	assign ox_r = XW'(o_q[1]);

	// read position from the wrapped length
	assign len_ext = CW'(len_q);
	assign len_big = (len_ext >= DEPTH_C);
	assign diff    = {1'b0, CW'(wp_q)} - {1'b0, len_ext};

	assign x = rd_ok_q ? (ch_q ? rd_q[2*SB-1:SB] : rd_q[SB-1:0]) : '0;

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_M0:   begin mul_a = {coef_b0_q[15], coef_b0_q}; mul_b = x;          end
			ST_M1:   begin mul_a = {coef_b1_q[15], coef_b1_q}; mul_b = x;          end
			ST_M3:   begin mul_a = {coef_a1_q[15], coef_a1_q}; mul_b = y_q;        end
			ST_M4:   begin mul_a = {1'b0, feedback_gain_q};    mul_b = y_q;        end
			ST_M5:   begin mul_a = {1'b0, nl_q};               mul_b = ns_q[ch_q]; end
			default: begin mul_a = '0;                         mul_b = '0;         end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign rnd   = (acc_q + HALF_C) >>> 14;
	assign sdiff = acc_q - ACC_W'(p_q);
	assign osum  = ACC_W'(fb_q) + ACC_W'($signed(p_q[PW-1:16]));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) state_d = ST_MOD;
			end
			ST_MOD: begin
				if (!len_big) state_d = ST_RD;
			end
			ST_RD: state_d = ST_M0;
			ST_M0: state_d = ST_M1;
			ST_M1: state_d = ST_M2;
			ST_M2: state_d = ST_M3;
			ST_M3: state_d = ST_M4;
			ST_M4: state_d = ST_M5;
			ST_M5: state_d = ST_M6;
			ST_M6: state_d = ch_q ? ST_WR : ST_M0;
			ST_WR: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q           <= '0;
			full_q         <= 1'b0;
			nl_q           <= '0;
			s_q[0]         <= '0;
			s_q[1]         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && sample.pluck) nl_q <= FULL_LEVEL;
				end
				ST_M4: s_q[ch_q] <= sat_32(sdiff);
				ST_WR: begin
					if (wp_q == LAST_POS) begin
						wp_q   <= '0;
						full_q <= 1'b1;
					end else begin
						wp_q <= wp_q + AW'(1);
					end
					nl_q <= (nl_q > noise_step_q) ? nl_q - noise_step_q : 16'd0;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		p_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				ns_q[0] <= ns_l;
				ns_q[1] <= ns_r;
				len_q   <= delay_length_q;
				ch_q    <= 1'b0;
			end
			ST_MOD: begin
				if (len_big) begin
					len_q <= DLEN_W'(len_ext - DEPTH_C);
				end else begin
					rp_q    <= AW'(diff[CW] ? diff + {1'b0, DEPTH_C} : diff);
					// entry written already once the line has wrapped or it lies behind wp
					rd_ok_q <= full_q || (!diff[CW] && (len_q != '0));
				end
			end
			ST_M1: acc_q <= ACC_W'(p_q) + ACC_W'(s_q[ch_q]);
			ST_M2: begin
				y_q   <= sat_s(rnd);
				acc_q <= ACC_W'(p_q);
			end
			ST_M5: fb_q <= $signed(p_q[PW-1:16]);
			ST_M6: begin
				o_q[ch_q] <= sat_s(osum);
				ch_q      <= 1'b1;
			end
			ST_OUT: begin
				if (out_free) begin
					result_q.out_left  <= 16'((ox_l >>> SH_UP) <<< SH_DN);
					result_q.out_right <= 16'((ox_r >>> SH_UP) <<< SH_DN);
				end
			end
			default: ;
		endcase
	end

	// delay line
	always_ff @(posedge clk) begin
		if (state_q == ST_WR) delay_mem[wp_q] <= {o_q[1], o_q[0]};
		if (state_q == ST_RD) rd_q <= delay_mem[rp_q];
	end

	`include "plucked_string_synth_top_assert.svh"

	`PSS_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !sample_ready, "ready high right after a transfer")
	`PSS_ASSERT_NEXT(a_level_no_rise, !(in_xfer && sample.pluck), nl_q <= $past(nl_q), "noise level rose without pluck")
	`PSS_ASSERT_NEXT(a_fill_sticky, full_q, full_q, "fill flag dropped")
	`PSS_ASSERT(a_len_wrapped, (state_q != ST_RD) || (len_ext < DEPTH_C), "length not wrapped at read")

endmodule

// ===== test/plucked_string_synth_top_test.sv =====
// ----------------------------------------------------------------------------
// plucked_string_synth_top_test
// drives sample ticks with random noise and plucks through the stereo string
// under many register settings, predicts every output frame bit-exactly
// and compares it with the block's result stream under random stalls
// ----------------------------------------------------------------------------
module plucked_string_synth_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pss_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_TICKS  = 125;
	localparam int RANDOM_PHASES = 6;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_ready;
	in_t                 sample = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	out_t                result;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	// predictor state
	logic signed [15:0]  line_l [0:1023];
	logic signed [15:0]  line_r [0:1023];
	logic [9:0]          wr_pos;
	logic [15:0]         noise_lvl;
	int                  filt_l;
	int                  filt_r;
	logic [15:0]         cfg_feedback;
	logic [9:0]          cfg_length;
	logic [15:0]         cfg_step;
	logic signed [15:0]  cfg_b0;
	logic signed [15:0]  cfg_b1;
	logic signed [15:0]  cfg_a1;

	in_t                 pending_ticks [$];
	out_t                expected_frames [$];
	out_t                due;
	int                  fail_cnt = 0;
	int                  cycle_cnt = 0;
	int                  src_gap = 0;
	int                  snk_gap = 0;
	bit                  idle_on = 1'b1;

	plucked_string_synth_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint clip(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// low-pass, loop gain and noise for one channel; longint >>> floors
	function automatic logic signed [15:0] string_channel(inout int fstate,
			input longint x, input logic signed [15:0] noise);
		longint acc;
		longint y;
		longint fb;
		longint nz;
		acc = longint'(cfg_b0) * x + longint'(fstate);
		y = clip((acc + 8192) >>> 14, 16);
		fstate = int'(clip(longint'(cfg_b1) * x - longint'(cfg_a1) * y, 32));
		fb = (longint'(cfg_feedback) * y) >>> 16;
		nz = (longint'(noise_lvl) * longint'(noise)) >>> 16;
		return 16'(clip(fb + nz, 16));
	endfunction

	function automatic out_t string_tick(input in_t s);
		logic [9:0] rd;
		out_t o;
		// 10-bit wrap gives the modulo of the delay depth
		rd = wr_pos - cfg_length;
		if (s.pluck) begin
			noise_lvl = FULL_LEVEL;
		end
		o.out_left = string_channel(filt_l, line_l[rd], s.noise_left);
		o.out_right = string_channel(filt_r, line_r[rd], s.noise_right);
		line_l[wr_pos] = o.out_left;
		line_r[wr_pos] = o.out_right;
		wr_pos = wr_pos + 10'd1;
		noise_lvl = (noise_lvl > cfg_step) ? noise_lvl - cfg_step : 16'd0;
		return o;
	endfunction

	task automatic report_fail(input string what, input int want, input int got);
		if (fail_cnt < 10) begin
			$display("mismatch %s: expected %0d, actual %0d", what, want, got);
		end
		fail_cnt++;
	endtask

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			src_gap = 0;
		end else begin
			if (sample_valid && sample_ready) begin
				expected_frames.push_back(string_tick(sample));
			end
			if (!sample_valid || sample_ready) begin
				if (src_gap > 0) begin
					src_gap--;
					sample_valid <= 1'b0;
				end else if (pending_ticks.size() == 0) begin
					sample_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					src_gap = $urandom_range(0, 10);
					sample_valid <= 1'b0;
				end else begin
					sample <= pending_ticks.pop_front();
					sample_valid <= 1'b1;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_frames.size() == 0) begin
					report_fail("transfer with no frame due, out_left", 0, result.out_left);
				end else begin
					due = expected_frames.pop_front();
					if (result.out_left !== due.out_left) begin
						report_fail("out_left", due.out_left, result.out_left);
					end
					if (result.out_right !== due.out_right) begin
						report_fail("out_right", due.out_right, result.out_right);
					end
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				result_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				snk_gap = $urandom_range(0, 10);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic reg_write(input int idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FEEDBACK_GAIN: cfg_feedback = val[15:0];
			REG_DELAY_LENGTH:  cfg_length = val[9:0];
			REG_NOISE_STEP:    cfg_step = val[15:0];
			REG_COEF_B0:       cfg_b0 = val[15:0];
			REG_COEF_B1:       cfg_b1 = val[15:0];
			REG_COEF_A1:       cfg_a1 = val[15:0];
			default: ;
		endcase
	endtask

	task automatic queue_tick(input logic pl, input logic [15:0] nl, input logic [15:0] nr);
		in_t s;
		s.pluck = pl;
		s.noise_left = nl;
		s.noise_right = nr;
		pending_ticks.push_back(s);
	endtask

	// block is idle once nothing is queued, in transfer or outstanding
	task automatic settle();
		do begin
			@(negedge clk);
		end while (pending_ticks.size() != 0 || sample_valid || expected_frames.size() != 0);
	endtask

	function automatic logic [15:0] wild16();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic pick_settings(input bit tuned);
		logic [15:0] fb;
		logic [9:0]  len;
		logic [15:0] stp;
		logic [15:0] b0;
		logic [15:0] b1;
		logic [15:0] a1;
		case ($urandom_range(0, 9))
			0: len = 10'd0;
			1: len = 10'd1023;
			2, 3: len = 10'($urandom_range(1, 1023));
			default: len = 10'($urandom_range(1, 24));
		endcase
		case ($urandom_range(0, 9))
			0: stp = 16'd0;
			1: stp = 16'hFFFF;
			default: stp = tuned ? 16'($urandom_range(1, 3000)) : 16'($urandom_range(1, 65535));
		endcase
		if (tuned) begin
			fb = 16'($urandom_range(56000, 65535));
			b0 = 16'($urandom_range(0, 4096));
			b1 = 16'($urandom_range(0, 4096));
			a1 = 16'(-$urandom_range(8000, 16000));
		end else begin
			fb = wild16();
			b0 = wild16();
			b1 = wild16();
			a1 = wild16();
		end
		// junk above the register width must be dropped
		reg_write(REG_FEEDBACK_GAIN, {16'($urandom), fb});
		reg_write(REG_DELAY_LENGTH, ($urandom & 32'hFFFF_FC00) | 32'(len));
		reg_write(REG_NOISE_STEP, {16'($urandom), stp});
		reg_write(REG_COEF_B0, {16'($urandom), b0});
		reg_write(REG_COEF_B1, {16'($urandom), b1});
		reg_write(REG_COEF_A1, {16'($urandom), a1});
	endtask

	initial begin
		int i;
		int ph;
		logic [15:0] nl;
		logic [15:0] nr;
		for (i = 0; i < 1024; i++) begin
			line_l[i] = '0;
			line_r[i] = '0;
		end
		wr_pos = '0;
		noise_lvl = '0;
		filt_l = 0;
		filt_r = 0;
		cfg_feedback = RST_FEEDBACK_GAIN;
		cfg_length = RST_DELAY_LENGTH;
		cfg_step = RST_NOISE_STEP;
		cfg_b0 = RST_COEF_B0;
		cfg_b1 = RST_COEF_B1;
		cfg_a1 = RST_COEF_A1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: noise extremes, pluck on the first tick
		queue_tick(1'b1, 16'h7FFF, 16'h8000);
		queue_tick(1'b0, 16'h8000, 16'h7FFF);
		queue_tick(1'b0, 16'h0000, 16'hFFFF);
		queue_tick(1'b1, 16'hFFFF, 16'h0001);
		queue_tick(1'b0, 16'h5555, 16'hAAAA);
		queue_tick(1'b0, 16'hAAAA, 16'h5555);
		queue_tick(1'b1, 16'h8000, 16'h8000);
		queue_tick(1'b0, 16'h7FFF, 16'h7FFF);
		settle();

		// zero delay, held noise level, saturating coefficients
		reg_write(REG_DELAY_LENGTH, 32'd0);
		reg_write(REG_NOISE_STEP, 32'd0);
		reg_write(REG_FEEDBACK_GAIN, 32'h0000_FFFF);
		reg_write(REG_COEF_B0, 32'h0000_7FFF);
		reg_write(REG_COEF_B1, 32'h0000_8000);
		reg_write(REG_COEF_A1, 32'h0000_8000);
		// addresses past the register list are ignored
		reg_write(int'(REG_COEF_A1) + 1, 32'hFFFF_FFFF);
		reg_write(int'(REG_COEF_A1) + 2, 32'h0000_0000);
		@(negedge clk);
		queue_tick(1'b1, 16'h7FFF, 16'h8000);
		queue_tick(1'b0, 16'h7FFF, 16'h8000);
		queue_tick(1'b0, 16'h8000, 16'h7FFF);
		queue_tick(1'b0, 16'hFFFF, 16'hFFFF);
		queue_tick(1'b1, 16'h0000, 16'h0000);
		queue_tick(1'b0, 16'h1234, 16'hEDCB);
		queue_tick(1'b0, 16'h7FFF, 16'h7FFF);
		queue_tick(1'b0, 16'h8000, 16'h8000);
		settle();

		// largest step drops the level to zero right after the pluck
		reg_write(REG_NOISE_STEP, 32'h0000_FFFF);
		reg_write(REG_DELAY_LENGTH, 32'd1);
		reg_write(REG_FEEDBACK_GAIN, 32'd0);
		reg_write(REG_COEF_B0, 32'h0000_8000);
		reg_write(REG_COEF_B1, 32'h0000_7FFF);
		reg_write(REG_COEF_A1, 32'h0000_7FFF);
		@(negedge clk);
		queue_tick(1'b1, 16'h7FFF, 16'h8000);
		queue_tick(1'b0, 16'h7FFF, 16'h8000);
		queue_tick(1'b1, 16'h8000, 16'h7FFF);
		queue_tick(1'b0, 16'h4000, 16'hC000);
		queue_tick(1'b0, 16'h0001, 16'hFFFE);
		queue_tick(1'b0, 16'h7FFF, 16'h7FFF);
		settle();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			pick_settings(ph % 2 == 0 || ph == RANDOM_PHASES - 1);
			// one stretch mid-run and the closing phase run without idling
			idle_on = (ph != 2 && ph != RANDOM_PHASES - 1);
			@(negedge clk);
			for (i = 0; i < PHASE_TICKS; i++) begin
				nl = ($urandom_range(0, 15) == 0) ? wild16() : 16'($urandom);
				nr = ($urandom_range(0, 15) == 0) ? wild16() : 16'($urandom);
				queue_tick(i == 0 || $urandom_range(0, 19) == 0, nl, nr);
			end
			settle();
		end

		repeat (40) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
